// ----- design/cau_pkg.sv -----
`timescale 1ns / 1ps
package cau_pkg;

    // Operation codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DBZ = 2'd2;

    // Quotient bits resolved by the divider, root steps of the square root unit.
    localparam int Q_BITS   = 17;
    localparam int SQ_STEPS = 17;
    // Register stages of the divider and of the square root unit.
    localparam int UNIT_LAT = 18;

    typedef struct packed {
        logic signed [15:0] val;
        logic               sat;
    } clamp_t;

    // Side data that travels beside the long units.
    typedef struct packed {
        logic [2:0]         kind;
        logic               dz;
        logic signed [15:0] rr;
        logic signed [15:0] ri;
        logic               sat;
    } side_t;

    function automatic clamp_t clamp16(input logic signed [33:0] v);
        clamp_t c;
        if (v > 34'sd32767) begin
            c.val = 16'sh7fff;
            c.sat = 1'b1;
        end else if (v < -34'sd32768) begin
            c.val = 16'sh8000;
            c.sat = 1'b1;
        end else begin
            c.val = v[15:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

// ----- design/complex_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   s_kind, s_a_real, s_a_imag, s_b_real, s_b_imag
// m_        out        m_valid / m_ready   m_result_real, m_result_imag, m_status
//
// One word is accepted per cycle while s_ready is high. A word passes 22 register
// stages: three front stages (operands, products, sums), 18 stages set by the
// bit-per-stage divider and square root units, and the output register. The first
// stage loads at the accepting edge.
// Reset clears only the valid bits of the pipeline.
// When a result waits on m_ready the whole pipeline holds; s_ready is low exactly then.
module complex_arithmetic_unit_core import cau_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_kind,
    input  logic signed [15:0] s_a_real,
    input  logic signed [15:0] s_a_imag,
    input  logic signed [15:0] s_b_real,
    input  logic signed [15:0] s_b_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_result_real,
    output logic signed [15:0] m_result_imag,
    output logic [1:0]         m_status
);

    localparam int LAT = 3 + UNIT_LAT + 1;

    logic en;
    logic [LAT-1:0] vld_reg;

    logic signed [32:0] num_r, num_i;
    logic [31:0]        den, sq;
    side_t              side_c;
    side_t              side_reg [UNIT_LAT];

    logic [Q_BITS-1:0]  q_r, q_i;
    logic               neg_r, neg_i, ovf_r, ovf_i;
    logic [16:0]        root;

    logic signed [15:0] rr_next, ri_next;
    logic [1:0]         st_next;
    logic signed [15:0] rr_reg, ri_reg;
    logic [1:0]         st_reg;

    // The pipeline moves whenever the output register is empty or being drained.
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk   (aclk),
        .en     (en),
        .kind   (s_kind),
        .a_real (s_a_real),
        .a_imag (s_a_imag),
        .b_real (s_b_real),
        .b_imag (s_b_imag),
        .num_r  (num_r),
        .num_i  (num_i),
        .den    (den),
        .sq     (sq),
        .side   (side_c)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_r (
        .aclk (aclk),
        .en   (en),
        .num  (num_r),
        .den  (den),
        .q    (q_r),
        .neg  (neg_r),
        .ovf  (ovf_r)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_i (
        .aclk (aclk),
        .en   (en),
        .num  (num_i),
        .den  (den),
        .q    (q_i),
        .neg  (neg_i),
        .ovf  (ovf_i)
    );

    cau_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .x    (sq),
        .root (root)
    );

    // Add, subtract and multiply results, plus the opcode, ride beside the long units.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_c;
            for (int i = 1; i < UNIT_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Final selection, signing of the quotients and saturation.
    always_comb begin
        side_t              sd;
        logic signed [33:0] vr, vi;
        clamp_t             cr, ci;
        sd = side_reg[UNIT_LAT-1];
        rr_next = '0;
        ri_next = '0;
        st_next = ST_OK;
        vr = neg_r ? -34'(q_r) : 34'(q_r);
        vi = neg_i ? -34'(q_i) : 34'(q_i);
        // A quotient past the resolved bits is forced out of range so it saturates.
        if (ovf_r) vr = neg_r ? -34'sd65536 : 34'sd65536;
        if (ovf_i) vi = neg_i ? -34'sd65536 : 34'sd65536;
        cr = clamp16(vr);
        ci = clamp16(vi);
        case (sd.kind)
            OP_ADD, OP_SUB, OP_MUL: begin
                rr_next = sd.rr;
                ri_next = sd.ri;
                st_next = sd.sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (sd.dz) begin
                    st_next = ST_DBZ;
                end else begin
                    rr_next = cr.val;
                    ri_next = ci.val;
                    st_next = (cr.sat || ci.sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                cr = clamp16(34'(root));
                rr_next = cr.val;
                st_next = cr.sat ? ST_SAT : ST_OK;
            end
            default: begin
                rr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg <= rr_next;
            ri_reg <= ri_next;
            st_reg <= st_next;
        end
    end

    assign m_valid       = vld_reg[LAT-1];
    assign m_result_real = rr_reg;
    assign m_result_imag = ri_reg;
    assign m_status      = st_reg;

endmodule

// ----- design/cau_front.sv -----
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [2:0]         kind,
    input  logic signed [15:0] a_real,
    input  logic signed [15:0] a_imag,
    input  logic signed [15:0] b_real,
    input  logic signed [15:0] b_imag,
    output logic signed [32:0] num_r,
    output logic signed [32:0] num_i,
    output logic [31:0]        den,
    output logic [31:0]        sq,
    output side_t              side
);

    // Stage A: operands.
    logic [2:0]         kind_a_reg;
    logic signed [15:0] ar_reg, ai_reg, br_reg, bi_reg;

    // Stage B: products and add/subtract results.
    logic [2:0]         kind_b_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] p_bb_r_reg, p_bb_i_reg, p_aa_r_reg, p_aa_i_reg;
    clamp_t             as_r_reg, as_i_reg;
    clamp_t             as_r_next, as_i_next;

    // Stage C: sums.
    logic signed [32:0] num_r_reg, num_i_reg;
    logic [31:0]        den_reg, sq_reg;
    side_t              side_reg, side_next;

    logic signed [33:0] half;
    logic signed [33:0] mr_sum, mi_sum;
    clamp_t             mr_c, mi_c;

    assign half = (FRAC_BITS > 0) ? (34'sd1 <<< (FRAC_BITS - 1)) : 34'sd0;

    always_comb begin
        if (kind_a_reg == OP_SUB) begin
            as_r_next = clamp16(34'(ar_reg) - 34'(br_reg));
            as_i_next = clamp16(34'(ai_reg) - 34'(bi_reg));
        end else begin
            as_r_next = clamp16(34'(ar_reg) + 34'(br_reg));
            as_i_next = clamp16(34'(ai_reg) + 34'(bi_reg));
        end
    end

    // Rounding to nearest with ties upward is a floor of the biased sum.
    always_comb begin
        mr_sum = (34'(p_rr_reg) - 34'(p_ii_reg) + half) >>> FRAC_BITS;
        mi_sum = (34'(p_ri_reg) + 34'(p_ir_reg) + half) >>> FRAC_BITS;
        mr_c   = clamp16(mr_sum);
        mi_c   = clamp16(mi_sum);
        side_next.kind = kind_b_reg;
        side_next.dz   = (p_bb_r_reg == 32'sd0) && (p_bb_i_reg == 32'sd0);
        if (kind_b_reg == OP_MUL) begin
            side_next.rr  = mr_c.val;
            side_next.ri  = mi_c.val;
            side_next.sat = mr_c.sat | mi_c.sat;
        end else begin
            side_next.rr  = as_r_reg.val;
            side_next.ri  = as_i_reg.val;
            side_next.sat = as_r_reg.sat | as_i_reg.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_a_reg <= kind;
            ar_reg     <= a_real;
            ai_reg     <= a_imag;
            br_reg     <= b_real;
            bi_reg     <= b_imag;

            kind_b_reg <= kind_a_reg;
            p_rr_reg   <= ar_reg * br_reg;
            p_ii_reg   <= ai_reg * bi_reg;
            p_ri_reg   <= ar_reg * bi_reg;
            p_ir_reg   <= ai_reg * br_reg;
            p_bb_r_reg <= br_reg * br_reg;
            p_bb_i_reg <= bi_reg * bi_reg;
            p_aa_r_reg <= ar_reg * ar_reg;
            p_aa_i_reg <= ai_reg * ai_reg;
            as_r_reg   <= as_r_next;
            as_i_reg   <= as_i_next;

            num_r_reg  <= 33'(p_rr_reg) + 33'(p_ii_reg);
            num_i_reg  <= 33'(p_ir_reg) - 33'(p_ri_reg);
            den_reg    <= p_bb_r_reg + p_bb_i_reg;
            sq_reg     <= p_aa_r_reg + p_aa_i_reg;
            side_reg   <= side_next;
        end
    end

    assign num_r = num_r_reg;
    assign num_i = num_i_reg;
    assign den   = den_reg;
    assign sq    = sq_reg;
    assign side  = side_reg;

endmodule

// ----- design/cau_div.sv -----
`timescale 1ns / 1ps
module cau_div import cau_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [32:0] num,
    input  logic [31:0]        den,
    output logic [Q_BITS-1:0]  q,
    output logic               neg,
    output logic               ovf
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int DW = 32 + Q_BITS;
    localparam int RW = (NW > DW) ? NW : DW;

    logic [RW-1:0]     rem_reg [Q_BITS+1];
    logic [31:0]       den_reg [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg   [Q_BITS+1];
    logic              neg_reg [Q_BITS+1];
    logic              ovf_reg [Q_BITS+1];

    logic [31:0]   mag;
    logic [RW-1:0] dividend;

    // Setup stage: magnitude, scaling, half-divisor bias and overflow test.
    always_comb begin
        mag      = num[32] ? 32'(-num) : 32'(num);
        dividend = (RW'(mag) << FRAC_BITS) + RW'(den >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= dividend;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[32];
            ovf_reg[0] <= dividend >= (RW'(den) << Q_BITS);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        localparam int B = Q_BITS - 1 - k;
        logic [RW-1:0] trial;
        logic          fits;
        assign trial = RW'(den_reg[k]) << B;
        assign fits  = rem_reg[k] >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? rem_reg[k] - trial : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (Q_BITS'(fits) << B);
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign q   = q_reg[Q_BITS];
    assign neg = neg_reg[Q_BITS];
    assign ovf = ovf_reg[Q_BITS];

endmodule

// ----- design/cau_sqrt.sv -----
`timescale 1ns / 1ps
module cau_sqrt import cau_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] x,
    output logic [16:0] root
);

    logic [33:0] res_reg [SQ_STEPS+1];
    logic [33:0] rem_reg [SQ_STEPS+1];
    logic [16:0] root_reg;

    assign res_reg[0] = '0;
    assign rem_reg[0] = 34'(x);

    // Digit-by-digit root, one result bit per stage.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam int SH = 2 * (SQ_STEPS - 1 - k);
        logic [33:0] bitv;
        logic [33:0] trial;
        assign bitv  = 34'd1 << SH;
        assign trial = res_reg[k] + bitv;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    res_reg[k+1] <= (res_reg[k] >> 1) + bitv;
                end else begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    // Round to nearest.
    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= res_reg[SQ_STEPS][16:0]
                      + 17'(rem_reg[SQ_STEPS] > res_reg[SQ_STEPS]);
        end
    end

    assign root = root_reg;

endmodule
